@@ sv/wsa_pkg.sv @@
// ----------------------------------------------------------------------------
// wsa_pkg
// types, constants and helpers shared by the slot apportioner modules
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int unsigned TIERS      = 3;
  localparam int unsigned BATCH_W    = 10;
  localparam int unsigned AVAIL_W    = 16;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned TOTAL_W    = 10;
  localparam int unsigned PROD_W     = BATCH_W + WEIGHT_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned DIV_STAGES = BATCH_W;

  localparam logic [BATCH_W-1:0]  BATCH_MAX  = BATCH_W'(1023);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(255);

  localparam logic [WEIGHT_W-1:0] WEIGHT_HIGH_RST   = WEIGHT_W'(4);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MEDIUM_RST = WEIGHT_W'(2);
  localparam logic [WEIGHT_W-1:0] WEIGHT_LOW_RST    = WEIGHT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_HIGH   = 2'd0,
    REG_WEIGHT_MEDIUM = 2'd1,
    REG_WEIGHT_LOW    = 2'd2
  } reg_idx_e;

  // classified request, front to back
  typedef struct packed {
    logic                             zero;
    logic [BATCH_W-1:0]               batch;
    logic [TOTAL_W-1:0]               total;
    logic [TIERS-1:0][PROD_W-1:0]     prod;
    logic [TIERS-1:0][AVAIL_W-1:0]    avail;
  } job_t;

  // divider pipeline stage contents
  typedef struct packed {
    logic                             zero;
    logic [BATCH_W-1:0]               batch;
    logic [TOTAL_W-1:0]               total;
    logic [TIERS-1:0][PROD_W-1:0]     rem;
    logic [TIERS-1:0][BATCH_W-1:0]    quo;
    logic [TIERS-1:0][AVAIL_W-1:0]    avail;
  } div_t;

  // shares after leftover slots are placed
  typedef struct packed {
    logic                             zero;
    logic [BATCH_W-1:0]               batch;
    logic [TIERS-1:0][BATCH_W-1:0]    share;
    logic [TIERS-1:0][AVAIL_W-1:0]    avail;
  } fin_t;

  function automatic logic [BATCH_W-1:0] sat_batch(input logic [BATCH_W-1:0] v);
    return (v > BATCH_MAX) ? BATCH_MAX : v;
  endfunction

  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] v);
    return (v > WEIGHT_MAX) ? WEIGHT_MAX : v;
  endfunction

endpackage

@@ sv/wsa_front.sv @@
// ----------------------------------------------------------------------------
// wsa_front
// weight registers, request intake, products and zero classification
// ----------------------------------------------------------------------------
module wsa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wsa_pkg::WEIGHT_W-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wsa_pkg::BATCH_W-1:0]        batch_i,
  input  logic [wsa_pkg::TIERS-1:0][wsa_pkg::AVAIL_W-1:0] avail_i,
  output logic                               push_o,
  output wsa_pkg::job_t                      job_o,
  input  logic                               full_i
);

  logic [wsa_pkg::TIERS-1:0][wsa_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic          fr_valid_q, fr_valid_d;
  wsa_pkg::job_t fr_job_q, job_c;
  logic          take;

  // config writes
  always_comb begin
    w_d = w_q;
    if (cfg_we_i) begin
      case (wsa_pkg::reg_idx_e'(cfg_idx_i))
        wsa_pkg::REG_WEIGHT_HIGH:   w_d[0] = cfg_data_i;
        wsa_pkg::REG_WEIGHT_MEDIUM: w_d[1] = cfg_data_i;
        wsa_pkg::REG_WEIGHT_LOW:    w_d[2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q[0] <= wsa_pkg::WEIGHT_HIGH_RST;
      w_q[1] <= wsa_pkg::WEIGHT_MEDIUM_RST;
      w_q[2] <= wsa_pkg::WEIGHT_LOW_RST;
    end else begin
      w_q <= w_d;
    end
  end

  // classify: saturate, total weight, products
  always_comb begin
    logic [wsa_pkg::BATCH_W-1:0]  b;
    logic [wsa_pkg::WEIGHT_W-1:0] ws;
    b               = wsa_pkg::sat_batch(batch_i);
    job_c.batch     = b;
    job_c.avail     = avail_i;
    job_c.total     = '0;
    for (int t = 0; t < wsa_pkg::TIERS; t++) begin
      ws = wsa_pkg::sat_weight(w_q[t]);
      job_c.total   = job_c.total + wsa_pkg::TOTAL_W'(ws);
      job_c.prod[t] = wsa_pkg::PROD_W'(b) * wsa_pkg::PROD_W'(ws);
    end
    job_c.zero      = (b == '0) || (job_c.total == '0);
  end

  assign push_o     = fr_valid_q && !full_i;
  assign in_ready_o = !fr_valid_q || !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign job_o      = fr_job_q;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (take) begin
      fr_valid_d = 1'b1;
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fr_job_q <= job_c;
    end
  end

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid_q && !push_o |=> fr_valid_q && $stable(fr_job_q))
    else $error("front stage lost a request while the queue was full");

endmodule

@@ sv/wsa_fifo.sv @@
// ----------------------------------------------------------------------------
// wsa_fifo
// short queue between front and back
// ----------------------------------------------------------------------------
module wsa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsa_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wsa_pkg::job_t data_o
);

  localparam int unsigned PTR_W = $clog2(wsa_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(wsa_pkg::Q_DEPTH + 1);

  wsa_pkg::job_t        mem_q [wsa_pkg::Q_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(wsa_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(wsa_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(wsa_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(wsa_pkg::Q_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

@@ sv/wsa_back.sv @@
// ----------------------------------------------------------------------------
// wsa_back
// pipelined division, largest remainder placement, capping and result register
// ----------------------------------------------------------------------------
module wsa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  wsa_pkg::job_t                 job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wsa_pkg::TIERS-1:0][wsa_pkg::BATCH_W-1:0] take_o
);

  localparam int unsigned N     = wsa_pkg::DIV_STAGES;
  localparam int unsigned DIV_W = wsa_pkg::PROD_W + 2;
  localparam int unsigned SUM_W = wsa_pkg::BATCH_W + 2;

  wsa_pkg::div_t   div_q [N];
  logic [N-1:0]    vld_q;
  wsa_pkg::fin_t   fin_q, fin_c;
  logic            fin_vld_q;
  logic            out_vld_q;
  logic [wsa_pkg::TIERS-1:0][wsa_pkg::BATCH_W-1:0] take_q, take_c;
  logic            adv;
  wsa_pkg::div_t   div_src0;

  // whole pipeline moves when the result register is free or drained
  assign adv         = !out_vld_q || out_ready_i;
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = out_vld_q;
  assign take_o      = take_q;

  always_comb begin
    div_src0.zero  = job_i.zero;
    div_src0.batch = job_i.batch;
    div_src0.total = job_i.total;
    div_src0.rem   = job_i.prod;
    div_src0.quo   = '0;
    div_src0.avail = job_i.avail;
  end

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < N; s++) begin : g_div
    localparam int unsigned K = N - 1 - s;
    wsa_pkg::div_t src, nxt;
    if (s == 0) begin : g_first
      assign src = div_src0;
    end else begin : g_rest
      assign src = div_q[s-1];
    end
    always_comb begin
      logic [DIV_W-1:0] dvs;
      nxt = src;
      dvs = DIV_W'(src.total) << K;
      for (int t = 0; t < wsa_pkg::TIERS; t++) begin
        if (DIV_W'(src.rem[t]) >= dvs) begin
          nxt.rem[t]    = src.rem[t] - wsa_pkg::PROD_W'(dvs);
          nxt.quo[t][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[s] <= nxt;
      end
    end
  end

  // leftover slots to the largest residues, ties to the higher tier
  always_comb begin
    logic [SUM_W-1:0] given;
    logic [1:0]       left;
    logic [1:0]       rank;
    wsa_pkg::div_t    d;
    d           = div_q[N-1];
    given       = '0;
    for (int t = 0; t < wsa_pkg::TIERS; t++) begin
      given = given + SUM_W'(d.quo[t]);
    end
    left        = 2'(SUM_W'(d.batch) - given);
    fin_c.zero  = d.zero;
    fin_c.batch = d.batch;
    fin_c.avail = d.avail;
    for (int i = 0; i < wsa_pkg::TIERS; i++) begin
      rank = '0;
      for (int j = 0; j < wsa_pkg::TIERS; j++) begin
        if (j != i) begin
          if ((d.rem[j] > d.rem[i]) || ((d.rem[j] == d.rem[i]) && (j < i))) begin
            rank = rank + 2'd1;
          end
        end
      end
      fin_c.share[i] = d.quo[i] + wsa_pkg::BATCH_W'(rank < left);
    end
  end

  // cap by availability, hand lost slots out from the high tier down
  always_comb begin
    logic [wsa_pkg::TIERS-1:0][wsa_pkg::AVAIL_W-1:0] tk;
    logic [wsa_pkg::AVAIL_W-1:0] spare;
    logic [wsa_pkg::AVAIL_W-1:0] lost;
    lost = '0;
    for (int t = 0; t < wsa_pkg::TIERS; t++) begin
      if (wsa_pkg::AVAIL_W'(fin_q.share[t]) < fin_q.avail[t]) begin
        tk[t] = wsa_pkg::AVAIL_W'(fin_q.share[t]);
      end else begin
        tk[t] = fin_q.avail[t];
      end
      lost = lost + (wsa_pkg::AVAIL_W'(fin_q.share[t]) - tk[t]);
    end
    for (int t = 0; t < wsa_pkg::TIERS; t++) begin
      spare = fin_q.avail[t] - tk[t];
      if (spare > lost) begin
        spare = lost;
      end
      tk[t] = tk[t] + spare;
      lost  = lost - spare;
    end
    for (int t = 0; t < wsa_pkg::TIERS; t++) begin
      take_c[t] = fin_q.zero ? '0 : tk[t][wsa_pkg::BATCH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[N-2:0], !empty_i};
      fin_vld_q <= vld_q[N-1];
      out_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q  <= fin_c;
      take_q <= take_c;
    end
  end

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q) && $stable(fin_vld_q))
    else $error("pipeline moved during a stall");

  a_shares_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && !fin_q.zero |->
      (SUM_W'(fin_q.share[0]) + SUM_W'(fin_q.share[1]) + SUM_W'(fin_q.share[2]))
        == SUM_W'(fin_q.batch))
    else $error("placed shares do not sum to the batch");

endmodule

@@ sv/weighted_slot_apportioner_top.sv @@
// ----------------------------------------------------------------------------
// weighted_slot_apportioner_top
// splits a batch of slots over three tiers by weight, largest remainder rule
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the result sink does not stall,
//   through the ten-stage restoring divider (one quotient bit per stage) that
//   all three tiers share in lockstep
// reset: asynchronous, active low; clears all valid state and the queue, weights
//   return to high 4, medium 2, low 1
// ----------------------------------------------------------------------------
module weighted_slot_apportioner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [wsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wsa_pkg::WEIGHT_W-1:0]  cfg_data_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // batch_size[9:0], avail_high[25:10], avail_medium[41:26], avail_low[57:42]
  input  logic [63:0]                   s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // take_high[9:0], take_medium[19:10], take_low[29:20]
  output logic [31:0]                   m_axis_tdata
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  wsa_pkg::job_t fr_job;
  wsa_pkg::job_t q_job;
  logic [wsa_pkg::TIERS-1:0][wsa_pkg::AVAIL_W-1:0] avail;
  logic [wsa_pkg::TIERS-1:0][wsa_pkg::BATCH_W-1:0] take;

  // unpack the request fields, high tier first
  assign avail[0] = s_axis_tdata[25:10];
  assign avail[1] = s_axis_tdata[41:26];
  assign avail[2] = s_axis_tdata[57:42];

  // front: holds the weights, takes a request, forms the products and
  // flags the all-zero cases
  wsa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .batch_i    (s_axis_tdata[9:0]),
    .avail_i    (avail),
    .push_o     (push),
    .job_o      (fr_job),
    .full_i     (full)
  );

  // two-entry queue so the front keeps taking requests while the back stalls
  wsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_job)
  );

  // back: division, leftover placement, availability cap, result register
  wsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (q_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .take_o      (take)
  );

  // pack the result, zero fill to whole bytes
  assign m_axis_tdata = {2'b00, take[2], take[1], take[0]};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted slot apportioner testbench
// drives apportionment requests with bursty gaps against a stalling result
// sink, predicts every grant with an independent largest remainder model and
// checks each result transaction field by field, over several weight settings
// ----------------------------------------------------------------------------
module testbench;

  // nominal pipeline depth of the block
  localparam int unsigned LATENCY     = 13;
  // quiet cycles after the last grant, to catch any stray result
  localparam int unsigned SETTLE      = 3 * LATENCY;
  // far beyond the slowest legal run (~1700 transactions)
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned PHASES      = 8;

  // an index past the register list, writes to it must be ignored
  localparam logic [wsa_pkg::CFG_IDX_W-1:0] REG_UNUSED = wsa_pkg::CFG_IDX_W'(3);

  // same layout as s_axis_tdata: batch in the low bits, then high, medium, low
  typedef struct packed {
    logic [wsa_pkg::TIERS-1:0][wsa_pkg::AVAIL_W-1:0] avail;
    logic [wsa_pkg::BATCH_W-1:0]                     batch;
  } request_t;

  // index 0 is the high tier, as in m_axis_tdata
  typedef logic [wsa_pkg::TIERS-1:0][wsa_pkg::BATCH_W-1:0] grant_t;

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_RARELY} rx_mode_e;

  // --------------------------------------------------------------------------
  // grant predictor and result store
  // --------------------------------------------------------------------------
  class grant_checker;
    logic [wsa_pkg::WEIGHT_W-1:0] weight [wsa_pkg::TIERS];
    grant_t                       expected_grants [$];
    int unsigned                  errors;
    string                        take_field [wsa_pkg::TIERS] =
                                    '{"take_high", "take_medium", "take_low"};

    function new();
      weight[0] = wsa_pkg::WEIGHT_HIGH_RST;
      weight[1] = wsa_pkg::WEIGHT_MEDIUM_RST;
      weight[2] = wsa_pkg::WEIGHT_LOW_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [wsa_pkg::CFG_IDX_W-1:0] idx,
                            logic [wsa_pkg::WEIGHT_W-1:0] value);
      case (idx)
        wsa_pkg::REG_WEIGHT_HIGH:   weight[0] = value;
        wsa_pkg::REG_WEIGHT_MEDIUM: weight[1] = value;
        wsa_pkg::REG_WEIGHT_LOW:    weight[2] = value;
        default: ;
      endcase
    endfunction

    // largest remainder split, then capping by availability with the lost
    // slots handed back from the highest tier down
    function grant_t apportion(request_t req);
      grant_t      g;
      int unsigned batch, total, given, lost, spare, best;
      int unsigned wt [wsa_pkg::TIERS];
      int unsigned share [wsa_pkg::TIERS];
      int unsigned resid [wsa_pkg::TIERS];
      int unsigned taken [wsa_pkg::TIERS];
      bit          used [wsa_pkg::TIERS];
      int          i, k;
      batch = (req.batch > wsa_pkg::BATCH_MAX) ? wsa_pkg::BATCH_MAX : req.batch;
      total = 0;
      given = 0;
      lost  = 0;
      for (i = 0; i < wsa_pkg::TIERS; i++) begin
        wt[i]    = (weight[i] > wsa_pkg::WEIGHT_MAX) ? wsa_pkg::WEIGHT_MAX : weight[i];
        total   += wt[i];
        share[i] = 0;
        resid[i] = 0;
        taken[i] = 0;
        used[i]  = 1'b0;
      end
      if (batch != 0 && total != 0) begin
        for (i = 0; i < wsa_pkg::TIERS; i++) begin
          share[i] = (batch * wt[i]) / total;
          resid[i] = (batch * wt[i]) % total;
          given   += share[i];
        end
        // strict compare keeps the higher tier on equal residues
        for (k = 0; k < wsa_pkg::TIERS && given < batch; k++) begin
          best = wsa_pkg::TIERS;
          for (i = 0; i < wsa_pkg::TIERS; i++) begin
            if (!used[i] && (best == wsa_pkg::TIERS || resid[i] > resid[best])) best = i;
          end
          used[best] = 1'b1;
          share[best]++;
          given++;
        end
        for (i = 0; i < wsa_pkg::TIERS; i++) begin
          taken[i] = (share[i] < req.avail[i]) ? share[i] : req.avail[i];
          lost    += share[i] - taken[i];
        end
        for (i = 0; i < wsa_pkg::TIERS && lost > 0; i++) begin
          spare = req.avail[i] - taken[i];
          if (spare > lost) spare = lost;
          taken[i] += spare;
          lost     -= spare;
        end
      end
      for (i = 0; i < wsa_pkg::TIERS; i++) g[i] = wsa_pkg::BATCH_W'(taken[i]);
      return g;
    endfunction

    function void note_request(request_t req);
      expected_grants.push_back(apportion(req));
    endfunction

    function void check_result(logic [31:0] tdata);
      grant_t                      want;
      logic [wsa_pkg::BATCH_W-1:0] got;
      int                          i;
      if (expected_grants.size() == 0) begin
        errors++;
        $error("result transaction with nothing expected, tdata %h", tdata);
        return;
      end
      want = expected_grants.pop_front();
      for (i = 0; i < wsa_pkg::TIERS; i++) begin
        got = tdata[i*wsa_pkg::BATCH_W +: wsa_pkg::BATCH_W];
        if (got !== want[i]) begin
          errors++;
          $error("%s: expected %0d, actual %0d", take_field[i], want[i], got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [wsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [wsa_pkg::WEIGHT_W-1:0]   cfg_data_i    = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // batch_size, avail_high, avail_medium, avail_low, zero padding
  logic [63:0]                    s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // take_high, take_medium, take_low, zero padding
  logic [31:0]                    m_axis_tdata;

  grant_checker ledger;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  weighted_slot_apportioner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // drivers: everything changes on the falling edge, sampled on the rising
  // --------------------------------------------------------------------------

  // present one request and hold it until the block takes it; valid is left
  // high so that the next call can follow on without a bubble
  task automatic send_request(input request_t req);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 64'(req);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_request(req);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // stop sending and let every outstanding grant come back, plus the pipeline
  task automatic drain();
    idle_sender(1);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wsa_pkg::WEIGHT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    ledger.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // weights only change with the pipeline empty; a stray write past the
  // register list goes along each time and must leave the weights alone
  task automatic set_weights(input logic [wsa_pkg::WEIGHT_W-1:0] high,
                             input logic [wsa_pkg::WEIGHT_W-1:0] mid,
                             input logic [wsa_pkg::WEIGHT_W-1:0] low);
    drain();
    write_reg(wsa_pkg::REG_WEIGHT_HIGH, high);
    write_reg(wsa_pkg::REG_WEIGHT_MEDIUM, mid);
    write_reg(wsa_pkg::REG_WEIGHT_LOW, low);
    write_reg(REG_UNUSED, wsa_pkg::WEIGHT_W'($urandom()));
  endtask

  function automatic request_t make_request(input int unsigned batch,
                                            input int unsigned high,
                                            input int unsigned mid,
                                            input int unsigned low);
    request_t r;
    r.batch    = wsa_pkg::BATCH_W'(batch);
    r.avail[0] = wsa_pkg::AVAIL_W'(high);
    r.avail[1] = wsa_pkg::AVAIL_W'(mid);
    r.avail[2] = wsa_pkg::AVAIL_W'(low);
    return r;
  endfunction

  // random requests in bursts; availability is often drawn near the share
  // sizes so that capping and the hand-back pass are hit a lot
  task automatic run_random(input int unsigned count);
    request_t    r;
    int unsigned sent, burst, i;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 32);
      while (burst != 0 && sent < count) begin
        case ($urandom_range(0, 9))
          0:       r.batch = '0;
          1:       r.batch = wsa_pkg::BATCH_MAX;
          2, 3:    r.batch = wsa_pkg::BATCH_W'($urandom_range(1, 16));
          default: r.batch = wsa_pkg::BATCH_W'($urandom());
        endcase
        for (i = 0; i < wsa_pkg::TIERS; i++) begin
          case ($urandom_range(0, 7))
            0:       r.avail[i] = '0;
            1:       r.avail[i] = '1;
            2, 3:    r.avail[i] = wsa_pkg::AVAIL_W'($urandom_range(0, r.batch));
            4:       r.avail[i] = wsa_pkg::AVAIL_W'($urandom_range(0, r.batch / 3 + 2));
            default: r.avail[i] = wsa_pkg::AVAIL_W'($urandom());
          endcase
        end
        send_request(r);
        sent++;
        burst--;
        // mid-phase the sender holds off until the block has emptied
        if (sent == count / 2) drain();
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // result sink: back-pressure in runs of differing character
  // --------------------------------------------------------------------------
  initial begin : result_backpressure
    rx_mode_e    mode;
    int unsigned run;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(1, 48);
      repeat (run) begin
        @(negedge clk_i);
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // every accepted result transaction is checked against the oldest grant
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) ledger.check_result(m_axis_tdata);
  end

  // watchdog
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int unsigned p;
    ledger = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset weights 4, 2, 1 (total 7)
    send_request(make_request(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));     // zero batch
    send_request(make_request(1023, 16'hFFFF, 16'hFFFF, 16'hFFFF));  // full batch
    send_request(make_request(1023, 0, 0, 0));                       // nothing available
    send_request(make_request(1, 16'hFFFF, 16'hFFFF, 16'hFFFF));     // single leftover
    send_request(make_request(3, 16'hFFFF, 16'hFFFF, 16'hFFFF));     // two leftovers
    send_request(make_request(7, 16'hFFFF, 16'hFFFF, 16'hFFFF));     // exact split
    send_request(make_request(1023, 0, 16'hFFFF, 16'hFFFF));         // high share moved down
    send_request(make_request(1023, 5, 6, 7));                       // too little availability
    send_request(make_request(100, 10, 16'hFFFF, 0));                // capped, handed back
    send_request(make_request(700, 400, 200, 100));                  // availability equals shares
    send_request(make_request(512, 16'h8000, 16'h7FFF, 16'h5555));
    send_request(make_request(341, 16'hAAAA, 3, 1));

    // equal weights: every residue ties, the higher tier must win
    set_weights(1, 1, 1);
    send_request(make_request(1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(2, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(1022, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(2, 0, 16'hFFFF, 16'hFFFF));

    // zero total weight gives all zeros whatever the request
    set_weights(0, 0, 0);
    send_request(make_request(1023, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(5, 1, 1, 1));

    // random phases over extreme and random weight settings
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_weights(255, 255, 255);
        1:       set_weights(255, 0, 0);
        2:       set_weights(0, 0, 255);
        3:       set_weights(1, 255, 0);
        4:       set_weights(wsa_pkg::WEIGHT_HIGH_RST, wsa_pkg::WEIGHT_MEDIUM_RST,
                             wsa_pkg::WEIGHT_LOW_RST);
        default: set_weights(wsa_pkg::WEIGHT_W'($urandom()), wsa_pkg::WEIGHT_W'($urandom()),
                             wsa_pkg::WEIGHT_W'($urandom()));
      endcase
      run_random(PHASE_ITEMS);
    end

    // let everything come home, then a quiet stretch for stray results
    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
